// ----- rtl/core/gbp_pkg.sv -----
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared types, constants and counter helpers for the gskew branch predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package gbp_pkg;

    // width of the branch address carried on the request channel
    localparam int PC_WIDTH = 64;

    // 2-bit saturating counter
    typedef logic [1:0] ctr_t;

    localparam ctr_t CTR_MIN   = 2'd0;
    localparam ctr_t CTR_MAX   = 2'd3;
    localparam ctr_t CTR_RESET = 2'd0;

    // control states, one-hot
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_READ  = 3'b100
    } state_t;

    // counter says taken when its upper bit is set
    function automatic logic ctr_taken(ctr_t c);
        return c[1];
    endfunction

    // saturating move toward the given direction
    function automatic ctr_t ctr_train(ctr_t c, logic up);
        ctr_t r;
        r = c;
        if (up)
        begin
            if (c != CTR_MAX)
            begin
                r = c + 2'd1;
            end
        end
        else
        begin
            if (c != CTR_MIN)
            begin
                r = c - 2'd1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gbp_if.sv -----
// ----------------------------------------------------------------------------
// gbp_if
// Valid/ready channels of the predictor: resolved branch in, prediction out.
// ----------------------------------------------------------------------------
`default_nettype none

// resolved branch word
interface gbp_req_if import gbp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PC_WIDTH-1:0] pc;
    logic                taken;

    modport source (output valid, output pc, output taken, input ready);
    modport sink   (input valid, input pc, input taken, output ready);
endinterface

// prediction word
interface gbp_rsp_if ();
    logic valid;
    logic ready;
    logic predicted_taken;
    logic mispredicted;

    modport source (output valid, output predicted_taken, output mispredicted, input ready);
    modport sink   (input valid, input predicted_taken, input mispredicted, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gbp_ram.sv -----
// ----------------------------------------------------------------------------
// gbp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gskew_branch_predictor_core.sv -----
// ----------------------------------------------------------------------------
// gskew_branch_predictor_core
// 2bc-gskew conditional branch predictor with training on resolved branches.
// ----------------------------------------------------------------------------
// Channel req carries one resolved branch (pc, taken); channel rsp returns one
// word per branch: the prediction formed from the tables before training
// (predicted_taken) and whether it missed the outcome (mispredicted).
// Four tables of 2-bit counters (bimodal, two skewed banks, chooser) sit in
// separate registered-read RAMs; a branch is read in the cycle after it is
// accepted, then the counters are written back and the history register
// shifts in the outcome in the same cycle that the result is registered.
// The result is valid once the branch has passed the READ state and the
// output register; a new branch is accepted only after the read-modify-write
// of the last one through the counter RAMs. Reset: the history clears at
// once; a clearing pass then zeroes all 2**INDEX_BITS entries, one entry per
// table per cycle, during which req.ready stays low.
// Stall: a result waits in the output register while rsp.ready is low; the
// next branch can still be accepted and read, and its write-back waits until
// the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module gskew_branch_predictor_core import gbp_pkg::*; #(
    parameter int INDEX_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    gbp_req_if.sink     req,
    gbp_rsp_if.source   rsp
);

    localparam int TABLE_SIZE = 1 << INDEX_BITS;

    typedef logic [INDEX_BITS-1:0] idx_t;

    state_t state_reg, state_next;
    idx_t   clr_cnt_reg, clr_cnt_next;
    idx_t   hist_reg, hist_next;

    // indices and outcome of the branch in flight
    idx_t ib_reg, i0_reg, i1_reg, im_reg;
    logic taken_reg;

    // output register
    logic rsp_valid_reg, rsp_valid_next;
    logic pred_reg, misp_reg;

    // index hashing on the incoming word
    idx_t p, hp, hh, ib, i0, i1, im;
    logic req_fire;

    // read data and write-back
    ctr_t rd_b, rd_0, rd_1, rd_m;
    logic pb, p0, p1, pm, maj, pred, outcome;
    logic rd_go;
    logic we_b, we_0, we_1, we_m;
    idx_t wa_b, wa_0, wa_1, wa_m;
    ctr_t wd_b, wd_0, wd_1, wd_m;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);

    // skewing hashes of pc and history
    always_comb
    begin
        p  = req.pc[INDEX_BITS-1:0];
        hp = {p[INDEX_BITS-1] ^ p[0], p[INDEX_BITS-1:1]};
        hh = '0;
        for (int k = 2; k < INDEX_BITS; k++)
        begin
            hh[k] = hist_reg[k-1];
        end
        hh[1] = hist_reg[0] | hist_reg[INDEX_BITS-1];
        hh[0] = hist_reg[INDEX_BITS-2] ^ hist_reg[INDEX_BITS-1];
        ib = p;
        i0 = hp ^ hh ^ hist_reg;
        i1 = hp ^ hh ^ p;
        im = idx_t'(p + hist_reg);
    end

    // capture indices of the accepted branch
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            ib_reg    <= ib;
            i0_reg    <= i0;
            i1_reg    <= i1;
            im_reg    <= im;
            taken_reg <= req.taken;
        end
    end

    // prediction from the read counters
    always_comb
    begin
        outcome = taken_reg;
        pb      = ctr_taken(rd_b);
        p0      = ctr_taken(rd_0);
        p1      = ctr_taken(rd_1);
        pm      = ctr_taken(rd_m);
        maj     = (pb & p0) | (p0 & p1) | (pb & p1);
        pred    = pm ? maj : pb;
        rd_go   = (state_reg == ST_READ) && (!rsp_valid_reg || rsp.ready);
    end

    // write-back: clearing pass or training
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            we_b = 1'b1;
            we_0 = 1'b1;
            we_1 = 1'b1;
            we_m = 1'b1;
            wa_b = clr_cnt_reg;
            wa_0 = clr_cnt_reg;
            wa_1 = clr_cnt_reg;
            wa_m = clr_cnt_reg;
            wd_b = CTR_RESET;
            wd_0 = CTR_RESET;
            wd_1 = CTR_RESET;
            wd_m = CTR_RESET;
        end
        else
        begin
            // all three train on a miss; on a hit only those that voted right,
            // or bimodal alone when the chooser is clear
            we_b = rd_go && ((pred != outcome) || !pm || (pb == outcome));
            we_0 = rd_go && ((pred != outcome) || (pm && (p0 == outcome)));
            we_1 = rd_go && ((pred != outcome) || (pm && (p1 == outcome)));
            we_m = rd_go && (pb != maj);
            wa_b = ib_reg;
            wa_0 = i0_reg;
            wa_1 = i1_reg;
            wa_m = im_reg;
            wd_b = ctr_train(rd_b, outcome);
            wd_0 = ctr_train(rd_0, outcome);
            wd_1 = ctr_train(rd_1, outcome);
            wd_m = ctr_train(rd_m, maj == outcome);
        end
    end

    // counter tables
    gbp_ram #(.WIDTH(2), .DEPTH(TABLE_SIZE)) u_bim_ram (
        .clk   (clk),
        .we    (we_b),
        .waddr (wa_b),
        .wdata (wd_b),
        .re    (req_fire),
        .raddr (ib),
        .rdata (rd_b)
    );

    gbp_ram #(.WIDTH(2), .DEPTH(TABLE_SIZE)) u_g0_ram (
        .clk   (clk),
        .we    (we_0),
        .waddr (wa_0),
        .wdata (wd_0),
        .re    (req_fire),
        .raddr (i0),
        .rdata (rd_0)
    );

    gbp_ram #(.WIDTH(2), .DEPTH(TABLE_SIZE)) u_g1_ram (
        .clk   (clk),
        .we    (we_1),
        .waddr (wa_1),
        .wdata (wd_1),
        .re    (req_fire),
        .raddr (i1),
        .rdata (rd_1)
    );

    gbp_ram #(.WIDTH(2), .DEPTH(TABLE_SIZE)) u_meta_ram (
        .clk   (clk),
        .we    (we_m),
        .waddr (wa_m),
        .wdata (wd_m),
        .re    (req_fire),
        .raddr (im),
        .rdata (rd_m)
    );

    // control next state
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        hist_next      = hist_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + idx_t'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (rd_go)
                begin
                    hist_next      = {hist_reg[INDEX_BITS-2:0], outcome};
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            hist_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            hist_reg      <= hist_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (rd_go)
        begin
            pred_reg <= pred;
            misp_reg <= (pred != outcome);
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.predicted_taken = pred_reg;
    assign rsp.mispredicted    = misp_reg;

    // miss flag agrees with the prediction and the outcome of the same branch
    a_misp_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        rd_go |=> ((pred_reg ^ misp_reg) == $past(taken_reg)))
        else $error("mispredicted flag inconsistent with prediction");

    // clearing pass ends after the last entry
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) && (clr_cnt_reg == '1) |=> (state_reg == ST_IDLE))
        else $error("clearing pass did not finish");

    // history moves only when a branch retires
    a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) && !rd_go |=> $stable(hist_reg))
        else $error("history changed without a retiring branch");

endmodule

`default_nettype wire
